@@ design/cbpc_pkg.sv @@
// cbpc_pkg: shared widths, function and motor command codes, register indexes
// for the calibrated blind position controller. No dependencies.
package cbpc_pkg;

  localparam int ENC_W      = 32;
  localparam int ANG_W      = 16;
  localparam int POS_W      = 16;
  localparam int TGT_W      = 15;
  localparam int TOL_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // quotient bits kept by the divider, step counter width
  localparam int QUO_W = 17;
  localparam int CNT_W = 5;
  // |reading - closed| * 100 fits in this many bits
  localparam int SCALE_W = 40;

  // smallest usable tilt span: just over 0.1 degree in 1/128 degree units
  localparam int MIN_ANGLE_SPAN = 13;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_TARGET = 2'd1,
    FUNC_STOP   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_STOP  = 2'd3
  } motor_cmd_e;

  localparam logic [CFG_IDX_W-1:0] REG_ENC_OPEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENC_CLOSED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_OPEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_CLOSED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 3'd4;

endpackage

@@ design/cbpc_if.sv @@
// Valid/ready channel interfaces: command input, result output, register writes.
// Depends on cbpc_pkg for field widths.
interface cbpc_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic signed [cbpc_pkg::ENC_W-1:0]   encoder_count;
  logic                                encoder_ok;
  logic signed [cbpc_pkg::ANG_W-1:0]   tilt_angle;
  logic                                tilt_ok;
  logic signed [cbpc_pkg::POS_W-1:0]   target_percent;

  modport source (output valid, func, encoder_count, encoder_ok, tilt_angle, tilt_ok,
                  target_percent, input ready);
  modport sink   (input valid, func, encoder_count, encoder_ok, tilt_angle, tilt_ok,
                  target_percent, output ready);
endinterface

interface cbpc_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          motor_cmd;
  logic signed [cbpc_pkg::POS_W-1:0]   position_now;
  logic                                moving_now;
  logic                                position_lost;

  modport source (output valid, motor_cmd, position_now, moving_now, position_lost,
                  input ready);
  modport sink   (input valid, motor_cmd, position_now, moving_now, position_lost,
                  output ready);
endinterface

interface cbpc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cbpc_pkg::CFG_IDX_W-1:0]      index;
  logic [cbpc_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/calibrated_blind_position_control.sv @@
// calibrated_blind_position_control: maps encoder or tilt readings onto a position
// and drives the motor toward a target. Depends on cbpc_pkg and cbpc_if.
// A tick with a usable sensor runs S_SETUP, S_SCALE, S_NUM, S_CHECK, S_DIV, S_FIN, with
// one shared compare/subtract unit doing a 17-step restoring divide. Ticks without a
// usable sensor go S_SETUP to S_FIN, target and stop commands straight to S_FIN. One item
// at a time; S_FIN holds while the output is full, then the next beat can be taken.
// Reset (async, active low): not moving, position and target 0, calibration 0,
// tolerance 256.
module calibrated_blind_position_control #(
  parameter int FRACTION_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cbpc_in_if.sink     in_i,
  cbpc_out_if.source  out_o,
  cbpc_cfg_if.sink    cfg_i
);

  localparam int FULL_SCALE = 100 << FRACTION_BITS;
  localparam int TOP_POS    = (FULL_SCALE > 32767) ? 32767 : FULL_SCALE;
  localparam int W          = FRACTION_BITS + 52;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_SCALE, S_NUM, S_CHECK, S_DIV, S_FIN
  } state_e;

  state_e state_q;

  // calibration
  logic signed [cbpc_pkg::ENC_W-1:0] enc_open_q, enc_closed_q;
  logic signed [cbpc_pkg::ANG_W-1:0] ang_open_q, ang_closed_q;
  logic [cbpc_pkg::TOL_W-1:0]        tol_q;

  // controller state
  logic signed [cbpc_pkg::POS_W-1:0] cur_q;
  logic [cbpc_pkg::TGT_W-1:0]        tgt_q;
  logic                              mov_q;

  // captured beat
  logic [1:0]                        func_q;
  logic signed [cbpc_pkg::ENC_W-1:0] enc_q;
  logic                              eok_q;
  logic signed [cbpc_pkg::ANG_W-1:0] tilt_q;
  logic                              tok_q;
  logic signed [cbpc_pkg::POS_W-1:0] tpct_q;

  // datapath
  logic [32:0]                       mag_q, den_q;
  logic                              neg_q, zero_q, ovf_q;
  logic [W-1:0]                      rem_q, dsor_q;
  logic [cbpc_pkg::QUO_W-1:0]        quo_q;
  logic [cbpc_pkg::CNT_W-1:0]        cnt_q;

  // output register
  logic                              out_valid_q;
  logic [1:0]                        out_cmd_q;
  logic signed [cbpc_pkg::POS_W-1:0] out_pos_q;
  logic                              out_mov_q;
  logic                              out_lost_q;

  assign in_i.ready   = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign out_o.valid         = out_valid_q;
  assign out_o.motor_cmd     = out_cmd_q;
  assign out_o.position_now  = out_pos_q;
  assign out_o.moving_now    = out_mov_q;
  assign out_o.position_lost = out_lost_q;

  logic in_fire, cfg_fire, commit;
  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign commit   = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  // source selection and span
  logic signed [32:0] enc_diff, enc_rng, sel_diff, sel_rng;
  logic signed [16:0] ang_diff, ang_rng, ang_abs;
  logic               enc_use, ang_use;
  logic [32:0]        mag_d, den_d;

  always_comb begin
    enc_diff = {enc_q[31], enc_q} - {enc_closed_q[31], enc_closed_q};
    enc_rng  = {enc_open_q[31], enc_open_q} - {enc_closed_q[31], enc_closed_q};
    ang_diff = {tilt_q[15], tilt_q} - {ang_closed_q[15], ang_closed_q};
    ang_rng  = {ang_open_q[15], ang_open_q} - {ang_closed_q[15], ang_closed_q};
    ang_abs  = ang_rng[16] ? -ang_rng : ang_rng;
    enc_use  = eok_q && !((enc_rng == 33'sd0) || (enc_rng == 33'sd1) ||
                          (enc_rng == -33'sd1));
    ang_use  = tok_q && (ang_abs >= 17'(cbpc_pkg::MIN_ANGLE_SPAN));
    if (enc_use) begin
      sel_diff = enc_diff;
      sel_rng  = enc_rng;
    end else begin
      sel_diff = {{16{ang_diff[16]}}, ang_diff};
      sel_rng  = {{16{ang_rng[16]}}, ang_rng};
    end
    mag_d = sel_diff[32] ? 33'(-sel_diff) : 33'(sel_diff);
    den_d = sel_rng[32] ? 33'(-sel_rng) : 33'(sel_rng);
  end

  // |diff| * 100 by shift and add
  logic [cbpc_pkg::SCALE_W-1:0] mag_ext, scaled;
  assign mag_ext = cbpc_pkg::SCALE_W'(mag_q);
  assign scaled  = (mag_ext << 6) + (mag_ext << 5) + (mag_ext << 2);

  logic div_ge;
  assign div_ge = (rem_q >= dsor_q);

  // rounded quotient, saturated
  logic signed [cbpc_pkg::POS_W-1:0] div_pos;
  logic [cbpc_pkg::QUO_W-1:0]        quo_neg;
  always_comb begin
    quo_neg = -quo_q;
    if (zero_q) begin
      div_pos = '0;
    end else if (neg_q) begin
      if (ovf_q || quo_q > cbpc_pkg::QUO_W'(32768)) begin
        div_pos = -16'sd32768;
      end else begin
        div_pos = cbpc_pkg::POS_W'(quo_neg);
      end
    end else begin
      if (ovf_q || quo_q > cbpc_pkg::QUO_W'(32767)) begin
        div_pos = 16'sd32767;
      end else begin
        div_pos = cbpc_pkg::POS_W'(quo_q);
      end
    end
  end

  // result of the item
  logic [1:0]                        fin_cmd;
  logic signed [cbpc_pkg::POS_W-1:0] fin_pos;
  logic                              fin_mov, fin_lost;
  logic [cbpc_pkg::TGT_W-1:0]        fin_tgt;
  logic signed [17:0]                pos_err, pos_err_abs;

  always_comb begin
    fin_cmd  = cbpc_pkg::CMD_NONE;
    fin_pos  = cur_q;
    fin_mov  = mov_q;
    fin_lost = 1'b0;
    fin_tgt  = tgt_q;
    pos_err     = {3'b000, tgt_q} - {{2{div_pos[15]}}, div_pos};
    pos_err_abs = pos_err[17] ? -pos_err : pos_err;
    case (func_q)
      cbpc_pkg::FUNC_TICK: begin
        if (!eok_q && !tok_q) begin
          fin_lost = 1'b1;
          if (mov_q) begin
            fin_cmd = cbpc_pkg::CMD_STOP;
            fin_mov = 1'b0;
          end
        end else begin
          fin_pos = div_pos;
          if (mov_q) begin
            if (pos_err_abs <= {3'b000, tol_q}) begin
              fin_cmd = cbpc_pkg::CMD_STOP;
              fin_mov = 1'b0;
            end else if (pos_err > 18'sd0) begin
              fin_cmd = cbpc_pkg::CMD_OPEN;
            end else begin
              fin_cmd = cbpc_pkg::CMD_CLOSE;
            end
          end
        end
      end
      cbpc_pkg::FUNC_TARGET: begin
        fin_mov = 1'b1;
        if (tpct_q < 16'sd0) begin
          fin_tgt = '0;
        end else if (tpct_q > 16'(TOP_POS)) begin
          fin_tgt = cbpc_pkg::TGT_W'(TOP_POS);
        end else begin
          fin_tgt = cbpc_pkg::TGT_W'(tpct_q);
        end
      end
      cbpc_pkg::FUNC_STOP: begin
        fin_cmd = cbpc_pkg::CMD_STOP;
        fin_mov = 1'b0;
      end
      default: ;
    endcase
  end

  // sequencer, controller state, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      enc_open_q   <= '0;
      enc_closed_q <= '0;
      ang_open_q   <= '0;
      ang_closed_q <= '0;
      tol_q        <= cbpc_pkg::TOL_W'(256);
      cur_q        <= '0;
      tgt_q        <= '0;
      mov_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_cmd_q    <= cbpc_pkg::CMD_NONE;
      out_pos_q    <= '0;
      out_mov_q    <= 1'b0;
      out_lost_q   <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (cfg_i.index)
          cbpc_pkg::REG_ENC_OPEN:   enc_open_q   <= cfg_i.data;
          cbpc_pkg::REG_ENC_CLOSED: enc_closed_q <= cfg_i.data;
          cbpc_pkg::REG_ANG_OPEN:   ang_open_q   <= cfg_i.data[cbpc_pkg::ANG_W-1:0];
          cbpc_pkg::REG_ANG_CLOSED: ang_closed_q <= cfg_i.data[cbpc_pkg::ANG_W-1:0];
          cbpc_pkg::REG_TOLERANCE:  tol_q        <= cfg_i.data[cbpc_pkg::TOL_W-1:0];
          default: ;
        endcase
      end

      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= (in_i.func == cbpc_pkg::FUNC_TICK) ? S_SETUP : S_FIN;
          end
        end
        S_SETUP: begin
          state_q <= (enc_use || ang_use) ? S_SCALE : S_FIN;
        end
        S_SCALE: state_q <= S_NUM;
        S_NUM:   state_q <= S_CHECK;
        S_CHECK: begin
          cnt_q   <= cbpc_pkg::CNT_W'(cbpc_pkg::QUO_W - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (commit) begin
            cur_q      <= fin_pos;
            tgt_q      <= fin_tgt;
            mov_q      <= fin_mov;
            out_cmd_q  <= fin_cmd;
            out_pos_q  <= fin_pos;
            out_mov_q  <= fin_mov;
            out_lost_q <= fin_lost;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // beat capture and divider datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= in_i.func;
      enc_q  <= in_i.encoder_count;
      eok_q  <= in_i.encoder_ok;
      tilt_q <= in_i.tilt_angle;
      tok_q  <= in_i.tilt_ok;
      tpct_q <= in_i.target_percent;
    end
    case (state_q)
      S_SETUP: begin
        mag_q  <= mag_d;
        den_q  <= den_d;
        neg_q  <= sel_diff[32] ^ sel_rng[32];
        zero_q <= !(enc_use || ang_use);
      end
      S_SCALE: rem_q <= W'(scaled);
      S_NUM: begin
        // numerator 2*|num| + |den|, divisor 2*|den| one place above the top quotient bit
        rem_q  <= (rem_q << (FRACTION_BITS + 1)) + W'(den_q);
        dsor_q <= W'(den_q) << (cbpc_pkg::QUO_W + 1);
      end
      S_CHECK: begin
        ovf_q  <= div_ge;
        dsor_q <= dsor_q >> 1;
        quo_q  <= '0;
      end
      S_DIV: begin
        if (div_ge) begin
          rem_q <= rem_q - dsor_q;
        end
        quo_q  <= {quo_q[cbpc_pkg::QUO_W-2:0], div_ge};
        dsor_q <= dsor_q >> 1;
      end
      default: ;
    endcase
  end

endmodule
